// ===== design/bsqm_pkg.sv =====
`timescale 1ns / 1ps
package bsqm_pkg;

  typedef enum logic [1:0] {
    REQ_QUEUE   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_CANCEL  = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_STREAM_LIM  = 2'd1,
    ST_BYTE_LIM    = 2'd2,
    ST_SECTION_LIM = 2'd3
  } status_t;

  localparam logic REG_MAX_STREAMS = 1'b0;
  localparam logic REG_MAX_BYTES   = 1'b1;

  localparam logic [3:0]  MAX_STREAMS_RESET = 4'd8;
  localparam logic [22:0] MAX_BYTES_RESET   = 23'd65536;

  typedef struct packed {
    logic [31:0] ric;
    logic [15:0] hnd;
    logic [15:0] len;
  } sec_rec_t;

  typedef struct packed {
    logic [61:0] sid;
    sec_rec_t    sec;
  } rel_rec_t;

endpackage

// ===== design/blocked_section_queue_manager.sv =====
`timescale 1ns / 1ps
// Queue, cancel and query scan the live streams before the first result.
// Advance first walks each stream's sections in the one-read-per-cycle section
// memory; each result beat then passes through S_EMIT_RD and S_EMIT_LD.
// One item is in work at a time; a new item is taken while the last result waits.
// Reset (rst, synchronous) empties the stream table and restores both limits.
module blocked_section_queue_manager #(
  parameter int MAX_STREAMS  = 8,
  parameter int MAX_SECTIONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [61:0] stream_key,
  input  logic [31:0] needed_count,
  input  logic [31:0] insert_count,
  input  logic [15:0] section_handle,
  input  logic [15:0] section_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        released_valid,
  output logic [61:0] out_stream_key,
  output logic [31:0] out_required_count,
  output logic [15:0] out_handle,
  output logic [15:0] out_length,
  output logic        last,
  output logic [6:0]  released_count,
  output logic        stream_is_blocked,
  output logic [3:0]  blocked_stream_count,
  output logic [22:0] blocked_bytes,
  output logic [31:0] min_blocked_count
);

  localparam int SW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CW    = $clog2(MAX_SECTIONS + 1);
  localparam int LW    = $clog2(MAX_STREAMS + 1);
  localparam int DEPTH = MAX_STREAMS * MAX_SECTIONS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int BW    = $clog2(MAX_SECTIONS) + 16;
  localparam int SECW  = $bits(bsqm_pkg::sec_rec_t);
  localparam int RELW  = $bits(bsqm_pkg::rel_rec_t);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECIDE    = 8'b0000_0010,
    S_ADV_START = 8'b0000_0100,
    S_ADV_SEC   = 8'b0000_1000,
    S_ADV_END   = 8'b0001_0000,
    S_SUM       = 8'b0010_0000,
    S_EMIT_RD   = 8'b0100_0000,
    S_EMIT_LD   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [3:0]  max_streams;
  logic [22:0] max_bytes;

  logic [61:0]   sid_tab   [MAX_STREAMS];
  logic [31:0]   smin_tab  [MAX_STREAMS];
  logic [BW-1:0] sbyte_tab [MAX_STREAMS];
  logic [CW-1:0] scnt_tab  [MAX_STREAMS];
  logic [SW-1:0] slot_tab  [MAX_STREAMS];
  logic [LW-1:0] live;
  logic [22:0]   total;

  bsqm_pkg::req_t req;
  logic [61:0] q_sid;
  logic [31:0] q_ric;
  logic [31:0] q_ic;
  logic [15:0] q_hnd;
  logic [15:0] q_len;

  logic [LW-1:0]  idx;
  logic [CW-1:0]  j;
  logic [CW-1:0]  w;
  logic [31:0]    kmin;
  logic [NW-1:0]  n;
  logic [NW-1:0]  k;
  logic [31:0]    run_min;
  bsqm_pkg::status_t res_status;
  logic           res_blocked;
  logic [31:0]    res_min;

  logic            hit;
  logic [SW-1:0]   hit_idx;
  logic [MAX_STREAMS-1:0] used;
  logic [SW-1:0]   free_slot;
  logic            free_found;
  logic [SW-1:0]   ii;
  logic [4:0]      lim;
  logic            byte_over;
  logic            stream_over;
  logic            sec_over;
  logic            q_ok;

  logic          drop_en;
  logic [SW-1:0] drop_idx;

  logic                  sec_we;
  logic [AW-1:0]         sec_waddr;
  bsqm_pkg::sec_rec_t    sec_wdata;
  logic                  sec_re;
  logic [AW-1:0]         sec_raddr;
  logic [SECW-1:0]       sec_rdata;
  bsqm_pkg::sec_rec_t    sec_rd;

  logic                  rel_we;
  bsqm_pkg::rel_rec_t    rel_wdata;
  logic                  rel_re;
  logic [RELW-1:0]       rel_rdata;
  bsqm_pkg::rel_rec_t    rel_rd;

  logic          release_hit;
  logic [AW-1:0] cur_base;
  logic          out_free;
  logic          is_last;

  assign ii       = idx[SW-1:0];
  assign sec_rd   = bsqm_pkg::sec_rec_t'(sec_rdata);
  assign rel_rd   = bsqm_pkg::rel_rec_t'(rel_rdata);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign cur_base = AW'(slot_tab[ii] * MAX_SECTIONS);
  assign release_hit = (sec_rd.ric <= q_ic);
  assign is_last  = (n == '0) || (k + NW'(1) == n);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    used    = '0;
    for (int e = 0; e < MAX_STREAMS; e++) begin
      if (LW'(e) < live) begin
        used[slot_tab[e]] = 1'b1;
        if (!hit && sid_tab[e] == q_sid) begin
          hit     = 1'b1;
          hit_idx = SW'(e);
        end
      end
    end
    free_slot  = '0;
    free_found = 1'b0;
    for (int e = 0; e < MAX_STREAMS; e++) begin
      if (!free_found && !used[e]) begin
        free_found = 1'b1;
        free_slot  = SW'(e);
      end
    end
  end

  always_comb begin
    lim = ({1'b0, max_streams} < 5'(MAX_STREAMS)) ? {1'b0, max_streams} : 5'(MAX_STREAMS);
    byte_over   = ({1'b0, total} + 24'(q_len)) > {1'b0, max_bytes};
    stream_over = !hit && (5'(live) >= lim);
    sec_over    = hit && (5'(scnt_tab[hit_idx]) >= 5'(MAX_SECTIONS));
    q_ok        = !byte_over && !stream_over && !sec_over;
  end

  always_comb begin
    drop_en  = 1'b0;
    drop_idx = ii;
    if (state == S_DECIDE && req == bsqm_pkg::REQ_CANCEL && hit) begin
      drop_en  = 1'b1;
      drop_idx = hit_idx;
    end else if (state == S_ADV_END && w == '0) begin
      drop_en = 1'b1;
    end
  end

  always_comb begin
    sec_we    = 1'b0;
    sec_waddr = cur_base + AW'(w);
    sec_wdata = sec_rd;
    sec_re    = 1'b0;
    sec_raddr = cur_base;
    if (state == S_DECIDE && req == bsqm_pkg::REQ_QUEUE && q_ok) begin
      sec_we = 1'b1;
      if (hit) begin
        sec_waddr = AW'(slot_tab[hit_idx] * MAX_SECTIONS) + AW'(scnt_tab[hit_idx]);
      end else begin
        sec_waddr = AW'(free_slot * MAX_SECTIONS);
      end
      sec_wdata.ric = q_ric;
      sec_wdata.hnd = q_hnd;
      sec_wdata.len = q_len;
    end else if (state == S_ADV_SEC) begin
      sec_we = !release_hit;
    end
    if (state == S_ADV_START) begin
      sec_re = 1'b1;
    end else if (state == S_ADV_SEC) begin
      sec_re    = (j + CW'(1)) < scnt_tab[ii];
      sec_raddr = cur_base + AW'(j + CW'(1));
    end
  end

  always_comb begin
    rel_we        = (state == S_ADV_SEC) && release_hit;
    rel_wdata.sid = sid_tab[ii];
    rel_wdata.sec = sec_rd;
    rel_re        = (state == S_EMIT_RD);
  end

  bsqm_ram #(.WIDTH(SECW), .DEPTH(DEPTH)) u_sec_ram (
    .clk   (clk),
    .we    (sec_we),
    .waddr (sec_waddr),
    .wdata (SECW'(sec_wdata)),
    .re    (sec_re),
    .raddr (sec_raddr),
    .rdata (sec_rdata)
  );

  bsqm_ram #(.WIDTH(RELW), .DEPTH(DEPTH)) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (n[AW-1:0]),
    .wdata (RELW'(rel_wdata)),
    .re    (rel_re),
    .raddr (k[AW-1:0]),
    .rdata (rel_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_streams <= bsqm_pkg::MAX_STREAMS_RESET;
      max_bytes   <= bsqm_pkg::MAX_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsqm_pkg::REG_MAX_STREAMS: max_streams <= cfg_data[3:0];
        bsqm_pkg::REG_MAX_BYTES:   max_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  // table payload: no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req   <= bsqm_pkg::req_t'(req_type);
      q_sid <= stream_key;
      q_ric <= needed_count;
      q_ic  <= insert_count;
      q_hnd <= section_handle;
      q_len <= section_length;
    end
    if (state == S_DECIDE && req == bsqm_pkg::REQ_QUEUE && q_ok) begin
      if (hit) begin
        scnt_tab[hit_idx]  <= scnt_tab[hit_idx] + CW'(1);
        sbyte_tab[hit_idx] <= sbyte_tab[hit_idx] + BW'(q_len);
        if (q_ric < smin_tab[hit_idx]) begin
          smin_tab[hit_idx] <= q_ric;
        end
      end else begin
        sid_tab[live[SW-1:0]]   <= q_sid;
        smin_tab[live[SW-1:0]]  <= q_ric;
        sbyte_tab[live[SW-1:0]] <= BW'(q_len);
        scnt_tab[live[SW-1:0]]  <= CW'(1);
        slot_tab[live[SW-1:0]]  <= free_slot;
      end
    end
    if (state == S_ADV_SEC && release_hit) begin
      sbyte_tab[ii] <= sbyte_tab[ii] - BW'(sec_rd.len);
    end
    if (state == S_ADV_END && w != '0) begin
      scnt_tab[ii] <= w;
      smin_tab[ii] <= kmin;
    end
    if (drop_en) begin
      for (int e = 0; e < MAX_STREAMS - 1; e++) begin
        if (LW'(e) >= LW'(drop_idx) && LW'(e + 1) < live) begin
          sid_tab[e]   <= sid_tab[e + 1];
          smin_tab[e]  <= smin_tab[e + 1];
          sbyte_tab[e] <= sbyte_tab[e + 1];
          scnt_tab[e]  <= scnt_tab[e + 1];
          slot_tab[e]  <= slot_tab[e + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      total     <= '0;
      idx       <= '0;
      j         <= '0;
      w         <= '0;
      n         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT_LD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          n       <= '0;
          idx     <= '0;
          run_min <= '1;
          case (req)
            bsqm_pkg::REQ_QUEUE: begin
              state <= S_SUM;
              if (byte_over) begin
                res_status <= bsqm_pkg::ST_BYTE_LIM;
              end else if (stream_over) begin
                res_status <= bsqm_pkg::ST_STREAM_LIM;
              end else if (sec_over) begin
                res_status <= bsqm_pkg::ST_SECTION_LIM;
              end else begin
                res_status <= bsqm_pkg::ST_OK;
                total <= total + 23'(q_len);
                if (!hit) begin
                  live <= live + LW'(1);
                end
              end
            end
            bsqm_pkg::REQ_ADVANCE: begin
              res_status <= bsqm_pkg::ST_OK;
              state      <= (live != '0) ? S_ADV_START : S_SUM;
            end
            bsqm_pkg::REQ_CANCEL: begin
              res_status <= bsqm_pkg::ST_OK;
              state      <= S_SUM;
              if (hit) begin
                total <= total - 23'(sbyte_tab[hit_idx]);
                live  <= live - LW'(1);
              end
            end
            default: begin
              res_status <= bsqm_pkg::ST_OK;
              state      <= S_SUM;
            end
          endcase
        end
        S_ADV_START: begin
          j     <= '0;
          w     <= '0;
          kmin  <= '1;
          state <= S_ADV_SEC;
        end
        S_ADV_SEC: begin
          if (release_hit) begin
            n     <= n + NW'(1);
            total <= total - 23'(sec_rd.len);
          end else begin
            w <= w + CW'(1);
            if (sec_rd.ric < kmin) begin
              kmin <= sec_rd.ric;
            end
          end
          j <= j + CW'(1);
          if ((j + CW'(1)) >= scnt_tab[ii]) begin
            state <= S_ADV_END;
          end
        end
        S_ADV_END: begin
          if (w == '0) begin
            live <= live - LW'(1);
            total <= total - 23'(sbyte_tab[ii]);
            if (idx + LW'(1) < live) begin
              state <= S_ADV_START;
            end else begin
              idx   <= '0;
              state <= S_SUM;
            end
          end else begin
            if (idx + LW'(1) < live) begin
              idx   <= idx + LW'(1);
              state <= S_ADV_START;
            end else begin
              idx   <= '0;
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (idx < live) begin
            if (smin_tab[ii] < run_min) begin
              run_min <= smin_tab[ii];
            end
            idx <= idx + LW'(1);
          end else begin
            res_min     <= (live == '0) ? '0 : run_min;
            res_blocked <= hit;
            k           <= '0;
            state       <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            last                 <= is_last;
            stream_is_blocked    <= res_blocked;
            blocked_stream_count <= 4'(live);
            blocked_bytes        <= total;
            min_blocked_count    <= res_min;
            if (n == '0) begin
              status             <= res_status;
              released_valid     <= 1'b0;
              out_stream_key     <= '0;
              out_required_count <= '0;
              out_handle         <= '0;
              out_length         <= '0;
              released_count     <= '0;
            end else begin
              status             <= bsqm_pkg::ST_OK;
              released_valid     <= 1'b1;
              out_stream_key     <= rel_rd.sid;
              out_required_count <= rel_rd.sec.ric;
              out_handle         <= rel_rd.sec.hnd;
              out_length         <= rel_rd.sec.len;
              released_count     <= 7'(k + NW'(1));
            end
            k     <= k + NW'(1);
            state <= is_last ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/bsqm_ram.sv =====
`timescale 1ns / 1ps
module bsqm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bsqm_chk.sv =====
`timescale 1ns / 1ps
module bsqm_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        released_valid,
  input logic [15:0] out_handle,
  input logic [15:0] out_length,
  input logic        last,
  input logic [6:0]  released_count,
  input logic        stream_is_blocked,
  input logic [3:0]  blocked_stream_count,
  input logic [22:0] blocked_bytes,
  input logic [31:0] min_blocked_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_handle) && $stable(last))
    else $error("stalled result beat changed");

  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !released_valid |-> last && released_count == 7'd0 && out_length == 16'd0)
    else $error("result without release is not a lone beat");

  a_release_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && released_valid |-> released_count != 7'd0 && status == 2'd0)
    else $error("release beat lacks count");

  a_empty_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && blocked_stream_count == 4'd0 |->
      min_blocked_count == 32'd0 && blocked_bytes == 23'd0 && !stream_is_blocked)
    else $error("empty table reports holdings");

endmodule

bind blocked_section_queue_manager bsqm_chk u_bsqm_chk (.*);

// ===== tb/blocked_section_queue_manager_checker.sv =====
`timescale 1ns / 1ps
module blocked_section_queue_manager_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [61:0] stream_key,
  input  logic [31:0] needed_count,
  input  logic [31:0] insert_count,
  input  logic [15:0] section_handle,
  input  logic [15:0] section_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic        released_valid,
  input  logic [61:0] out_stream_key,
  input  logic [31:0] out_required_count,
  input  logic [15:0] out_handle,
  input  logic [15:0] out_length,
  input  logic        last,
  input  logic [6:0]  released_count,
  input  logic        stream_is_blocked,
  input  logic [3:0]  blocked_stream_count,
  input  logic [22:0] blocked_bytes,
  input  logic [31:0] min_blocked_count,
  output int          fail_count,
  output int          pending_count
);

  localparam int NS = 8;
  localparam int NC = 8;

  typedef struct packed {
    logic [1:0]  st;
    logic        rv;
    logic [61:0] sid;
    logic [31:0] ric;
    logic [15:0] hnd;
    logic [15:0] len;
    logic        lst;
    logic [6:0]  rc;
    logic        blk;
    logic [3:0]  nstr;
    logic [22:0] bytes;
    logic [31:0] minc;
  } beat_t;

  beat_t release_queue[$];

  logic [3:0]  lim_streams;
  logic [22:0] lim_bytes;
  logic [61:0] tbl_id  [NS];
  logic [31:0] tbl_min [NS];
  logic [22:0] tbl_sum [NS];
  int          tbl_cnt [NS];
  logic [31:0] sec_ric [NS][NC];
  logic [15:0] sec_hnd [NS][NC];
  logic [15:0] sec_len [NS][NC];
  int          live;
  logic [22:0] held;

  function automatic int find_stream(logic [61:0] id);
    for (int i = 0; i < live; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [31:0] lowest_count();
    logic [31:0] m;
    if (live == 0) return 0;
    m = tbl_min[0];
    for (int i = 1; i < live; i++)
      if (tbl_min[i] < m) m = tbl_min[i];
    return m;
  endfunction

  task automatic remove_stream(int idx);
    held = held - tbl_sum[idx];
    for (int i = idx; i + 1 < live; i++) begin
      tbl_id[i] = tbl_id[i+1];
      tbl_min[i] = tbl_min[i+1];
      tbl_sum[i] = tbl_sum[i+1];
      tbl_cnt[i] = tbl_cnt[i+1];
      for (int j = 0; j < NC; j++) begin
        sec_ric[i][j] = sec_ric[i+1][j];
        sec_hnd[i][j] = sec_hnd[i+1][j];
        sec_len[i][j] = sec_len[i+1][j];
      end
    end
    live--;
  endtask

  task automatic predict_request(logic [1:0] rq, logic [61:0] sid, logic [31:0] ric,
                                 logic [31:0] ic, logic [15:0] hnd, logic [15:0] len);
    beat_t b;
    beat_t outs[$];
    logic [1:0] st;
    int idx, lim, s, c, i, w, n;
    logic [31:0] m;
    st = bsqm_pkg::ST_OK;
    n = 0;
    case (rq)
      bsqm_pkg::REQ_QUEUE: begin
        idx = find_stream(sid);
        lim = (lim_streams < NS) ? lim_streams : NS;
        if ({1'b0, held} + len > {1'b0, lim_bytes}) st = bsqm_pkg::ST_BYTE_LIM;
        else if (idx < 0 && live >= lim) st = bsqm_pkg::ST_STREAM_LIM;
        else if (idx >= 0 && tbl_cnt[idx] >= NC) st = bsqm_pkg::ST_SECTION_LIM;
        else begin
          if (idx < 0) begin
            s = live;
            tbl_id[s] = sid;
            tbl_min[s] = ric;
            tbl_sum[s] = 0;
            tbl_cnt[s] = 0;
            live++;
          end else s = idx;
          c = tbl_cnt[s];
          sec_ric[s][c] = ric;
          sec_hnd[s][c] = hnd;
          sec_len[s][c] = len;
          tbl_cnt[s] = c + 1;
          tbl_sum[s] = tbl_sum[s] + len;
          held = held + len;
          if (ric < tbl_min[s]) tbl_min[s] = ric;
        end
      end
      bsqm_pkg::REQ_ADVANCE: begin
        i = 0;
        while (i < live) begin
          w = 0;
          for (int j = 0; j < tbl_cnt[i]; j++) begin
            if (sec_ric[i][j] <= ic) begin
              b = '0;
              b.rv = 1'b1;
              b.sid = tbl_id[i];
              b.ric = sec_ric[i][j];
              b.hnd = sec_hnd[i][j];
              b.len = sec_len[i][j];
              b.rc = 7'(n + 1);
              tbl_sum[i] = tbl_sum[i] - sec_len[i][j];
              held = held - sec_len[i][j];
              outs.push_back(b);
              n++;
            end else begin
              sec_ric[i][w] = sec_ric[i][j];
              sec_hnd[i][w] = sec_hnd[i][j];
              sec_len[i][w] = sec_len[i][j];
              w++;
            end
          end
          tbl_cnt[i] = w;
          if (w == 0) remove_stream(i);
          else begin
            m = sec_ric[i][0];
            for (int j = 1; j < w; j++)
              if (sec_ric[i][j] < m) m = sec_ric[i][j];
            tbl_min[i] = m;
            i++;
          end
        end
      end
      bsqm_pkg::REQ_CANCEL: begin
        idx = find_stream(sid);
        if (idx >= 0) remove_stream(idx);
      end
      default: ;
    endcase
    if (outs.size() == 0) begin
      b = '0;
      b.st = st;
      outs.push_back(b);
    end
    foreach (outs[k]) begin
      b = outs[k];
      b.lst = (k == outs.size() - 1);
      b.blk = (find_stream(sid) >= 0);
      b.nstr = 4'(live);
      b.bytes = held;
      b.minc = lowest_count();
      release_queue.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (rst) begin
      lim_streams <= bsqm_pkg::MAX_STREAMS_RESET;
      lim_bytes <= bsqm_pkg::MAX_BYTES_RESET;
      live = 0;
      held = 0;
      fail_count = 0;
      release_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == bsqm_pkg::REG_MAX_STREAMS) lim_streams <= cfg_data[3:0];
        else lim_bytes <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = '{status, released_valid, out_stream_key, out_required_count, out_handle,
                out_length, last, released_count, stream_is_blocked,
                blocked_stream_count, blocked_bytes, min_blocked_count};
        if (release_queue.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          fail_count++;
        end else begin
          want = release_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_request(req_type, stream_key, needed_count, insert_count,
                        section_handle, section_length);
    end
    pending_count = release_queue.size();
  end

endmodule

// ===== tb/blocked_section_queue_manager_tb.sv =====
`timescale 1ns / 1ps
module blocked_section_queue_manager_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [22:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  req_type = 0;
  logic [61:0] stream_key = 0;
  logic [31:0] needed_count = 0;
  logic [31:0] insert_count = 0;
  logic [15:0] section_handle = 0;
  logic [15:0] section_length = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic        released_valid;
  logic [61:0] out_stream_key;
  logic [31:0] out_required_count;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic        last;
  logic [6:0]  released_count;
  logic        stream_is_blocked;
  logic [3:0]  blocked_stream_count;
  logic [22:0] blocked_bytes;
  logic [31:0] min_blocked_count;
  int          fail_count;
  int          pending_count;
  int          quiet_cycles = 0;
  logic [61:0] id_pool[6];

  localparam int QUIET_LIMIT = 20000;

  always #5 clk = ~clk;

  blocked_section_queue_manager dut (.*);
  blocked_section_queue_manager_checker chk (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int g;
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g > 0 && $urandom_range(0, 99) < 40) begin
        out_stall <= 1;
        repeat (g) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_beat(logic [1:0] rq, logic [61:0] sid, logic [31:0] ric,
                           logic [31:0] ic, logic [15:0] hnd, logic [15:0] len,
                           bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    stream_key <= sid;
    needed_count <= ric;
    insert_count <= ic;
    section_handle <= hnd;
    section_length <= len;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic idx, logic [22:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count, int pool, logic [31:0] span);
    int r;
    logic [61:0] sid;
    logic [15:0] len;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      sid = ($urandom_range(0, 19) == 0) ? 62'({$urandom, $urandom})
                                          : id_pool[$urandom_range(0, pool-1)];
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
      if (r < 60)
        send_beat(bsqm_pkg::REQ_QUEUE, sid, $urandom_range(0, span), 0, 16'($urandom),
                  len, 1);
      else if (r < 78)
        send_beat(bsqm_pkg::REQ_ADVANCE, sid, $urandom, $urandom_range(0, span),
                  16'($urandom), 16'($urandom), 1);
      else if (r < 90)
        send_beat(bsqm_pkg::REQ_CANCEL, sid, $urandom, $urandom, 16'($urandom),
                  16'($urandom), 1);
      else
        send_beat(bsqm_pkg::REQ_QUERY, sid, $urandom, $urandom, 16'($urandom),
                  16'($urandom), 1);
    end
  endtask

  initial begin
    logic [61:0] all1;
    all1 = '1;
    foreach (id_pool[i]) id_pool[i] = 62'({$urandom, $urandom});
    id_pool[0] = 0;
    id_pool[1] = all1;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_beat(bsqm_pkg::REQ_ADVANCE, 0, 0, 0, 0, 0, 0);
    send_beat(bsqm_pkg::REQ_QUERY, all1, 0, 0, 0, 0, 0);
    send_beat(bsqm_pkg::REQ_CANCEL, 5, 0, 0, 0, 0, 0);
    send_beat(bsqm_pkg::REQ_QUEUE, all1, '1, 0, 16'hffff, 0, 0);
    send_beat(bsqm_pkg::REQ_QUEUE, 0, 0, 0, 0, 16'hffff, 0);
    send_beat(bsqm_pkg::REQ_QUEUE, 0, 5, 0, 1, 16'hffff, 0);
    for (int i = 0; i < 9; i++)
      send_beat(bsqm_pkg::REQ_QUEUE, 7, 100 - i, 0, 16'(i), 1, 0);
    for (int i = 0; i < 8; i++)
      send_beat(bsqm_pkg::REQ_QUEUE, 62'(20 + i), 50, 0, 16'(i), 2, 0);
    send_beat(bsqm_pkg::REQ_QUERY, 7, 0, 0, 0, 0, 0);
    send_beat(bsqm_pkg::REQ_ADVANCE, 0, 0, 95, 0, 0, 0);
    send_beat(bsqm_pkg::REQ_CANCEL, 7, 0, 0, 0, 0, 0);
    send_beat(bsqm_pkg::REQ_ADVANCE, 0, 0, '1, 0, 0, 0);

    write_reg(bsqm_pkg::REG_MAX_STREAMS, 0);
    write_reg(bsqm_pkg::REG_MAX_BYTES, 23'h400000);
    send_beat(bsqm_pkg::REQ_QUEUE, 3, 1, 0, 2, 3, 0);
    write_reg(bsqm_pkg::REG_MAX_STREAMS, 4'hf);
    random_phase(100, 6, 200);
    write_reg(bsqm_pkg::REG_MAX_STREAMS, 2);
    write_reg(bsqm_pkg::REG_MAX_BYTES, 2000);
    random_phase(80, 6, 200);
    write_reg(bsqm_pkg::REG_MAX_BYTES, 0);
    random_phase(20, 3, 50);
    write_reg(bsqm_pkg::REG_MAX_STREAMS, 8);
    write_reg(bsqm_pkg::REG_MAX_BYTES, 23'h7fffff);
    random_phase(160, 6, 400);
    send_beat(bsqm_pkg::REQ_ADVANCE, 0, 0, '1, 0, 0, 0);

    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bsqm_pkg.sv
design/bsqm_ram.sv
design/blocked_section_queue_manager.sv
design/bsqm_chk.sv
tb/blocked_section_queue_manager_checker.sv
tb/blocked_section_queue_manager_tb.sv
